/* hdl/fps_pkg.sv */
// Package with the types, codes and constants of the file packet server.
package fps_pkg;

	localparam int DEF_STORE_DEPTH = 65536;
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW = $clog2(FQ_DEPTH);
	localparam int FQ_CW = $clog2(FQ_DEPTH + 1);

	localparam logic [11:0] PACKET_SIZE_RST = 12'h100;

	localparam logic [7:0] CMD_SIZE = 8'hA1;
	localparam logic [7:0] CMD_PSIZE = 8'hA2;
	localparam logic [7:0] CMD_STREAM = 8'hA3;
	localparam logic [7:0] CMD_BACK = 8'hA4;
	localparam logic [7:0] CMD_LANE0 = 8'hAA;
	localparam logic [7:0] CMD_LANE1 = 8'hAB;
	localparam logic [7:0] CMD_LANE2 = 8'hAC;
	localparam logic [7:0] CMD_END = 8'hAF;

	typedef enum logic [1:0] {
		OP_LINK = 2'd0,
		OP_LOAD = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	typedef enum logic [0:0] {
		REG_FILE_LENGTH = 1'b0,
		REG_OK_CODE = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_LANE = 5'b00010,
		PH_SIZE = 5'b00100,
		PH_STREAM = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		LANE_0 = 2'd0,
		LANE_1 = 2'd1,
		LANE_2 = 2'd2
	} lane_t;

	// One queued reply; a size reply carries four bytes in data, sent low byte first.
	typedef struct packed {
		logic multi;
		logic [31:0] data;
		logic txv;
		logic last;
		logic done;
		logic unk;
	} desc_t;

endpackage

/* hdl/file_packet_server.sv */
// Top level of the file packet server: command decode, file store and reply queue.
//
// The block takes one word per cycle on the input channel. A link word or a
// transmit tick is decoded in the cycle it is accepted; a tick that streams
// data reads the file store, a synchronous memory with a registered read, and
// its byte and the running checksum are formed in the following stage. Replies
// wait in a four-entry queue in front of the output; the size reply goes out
// as four byte beats, every other reply as a single word. The input stalls only
// when that queue, counting the word in the stage ahead of it, could overflow.
// The store is not cleared at reset; entries must be loaded before a stream
// reads them.
module file_packet_server
	import fps_pkg::*;
#(
	parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic [7:0] rx_byte,
	input logic [15:0] load_addr,
	input logic [7:0] load_byte,
	output logic out_valid,
	input logic out_ready,
	output logic tx_valid,
	output logic [7:0] tx_byte,
	output logic last_of_reply,
	output logic session_done,
	output logic unknown_command,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [23:0] cfg_data
);

	localparam int STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [23:0] file_length_q;
	logic [7:0] ok_code_q;

	phase_t phase_q, phase_nxt;
	lane_t lane_q, lane_nxt;
	logic [23:0] pointer_q, pointer_nxt;
	logic [11:0] psize_q, psize_nxt;
	logic [11:0] count_q, count_nxt;
	logic [7:0] checksum_q;

	logic [7:0] store_mem [STORE_DEPTH];
	logic [7:0] rd_data_s1;
	logic rd_en;
	logic [23:0] rd_addr;
	logic [STORE_AW-1:0] rd_idx;
	logic rd_inr;
	logic wr_en;

	logic in_fire;
	logic emit_s0, data_s0, csum_s0;
	desc_t desc_s0;

	logic v_s1, data_s1, csum_s1, inr_s1;
	desc_t desc_s1;
	desc_t push_desc;
	logic [7:0] data_byte;

	desc_t fq_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FQ_CW-1:0] fq_cnt_q;
	logic [1:0] beat_q;
	desc_t head;
	logic push, pop, out_fire, last_beat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
			ok_code_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FILE_LENGTH: file_length_q <= cfg_data;
				REG_OK_CODE: ok_code_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_ready = (fq_cnt_q + FQ_CW'(v_s1)) < FQ_CW'(FQ_DEPTH);
	assign in_fire = in_valid && in_ready;

	assign rd_addr = pointer_q + {12'd0, count_q};
	assign rd_idx = STORE_AW'(rd_addr);
	assign rd_inr = (rd_addr < file_length_q) && ({1'b0, rd_addr} < 25'(STORE_DEPTH));
	assign wr_en = in_fire && (op_t'(opcode) == OP_LOAD)
		&& ({9'd0, load_addr} < 25'(STORE_DEPTH));

	always_comb begin
		phase_nxt = phase_q;
		lane_nxt = lane_q;
		pointer_nxt = pointer_q;
		psize_nxt = psize_q;
		count_nxt = count_q;
		emit_s0 = 1'b0;
		data_s0 = 1'b0;
		csum_s0 = 1'b0;
		rd_en = 1'b0;
		desc_s0 = '0;
		if (in_fire) begin
			unique case (op_t'(opcode))
				OP_LINK: begin
					unique case (phase_q)
						PH_LANE: begin
							unique case (lane_q)
								LANE_0: pointer_nxt[7:0] = rx_byte;
								LANE_1: pointer_nxt[15:8] = rx_byte;
								LANE_2: pointer_nxt[23:16] = rx_byte;
								default: ;
							endcase
							phase_nxt = PH_IDLE;
							emit_s0 = 1'b1;
							desc_s0.txv = 1'b1;
							desc_s0.data = {24'd0, ok_code_q};
							desc_s0.last = 1'b1;
						end
						PH_SIZE: begin
							psize_nxt = {rx_byte, 4'd0};
							phase_nxt = PH_IDLE;
							emit_s0 = 1'b1;
							desc_s0.txv = 1'b1;
							desc_s0.data = {24'd0, ok_code_q};
							desc_s0.last = 1'b1;
						end
						PH_IDLE: begin
							case (rx_byte)
								CMD_SIZE: begin
									emit_s0 = 1'b1;
									desc_s0.multi = 1'b1;
									desc_s0.txv = 1'b1;
									desc_s0.data = {file_length_q, ok_code_q};
								end
								CMD_LANE0: begin
									lane_nxt = LANE_0;
									phase_nxt = PH_LANE;
								end
								CMD_LANE1: begin
									lane_nxt = LANE_1;
									phase_nxt = PH_LANE;
								end
								CMD_LANE2: begin
									lane_nxt = LANE_2;
									phase_nxt = PH_LANE;
								end
								CMD_PSIZE: phase_nxt = PH_SIZE;
								CMD_STREAM: begin
									count_nxt = '0;
									phase_nxt = PH_STREAM;
								end
								CMD_BACK: begin
									pointer_nxt = pointer_q - {12'd0, psize_q};
									emit_s0 = 1'b1;
									desc_s0.txv = 1'b1;
									desc_s0.data = {24'd0, ok_code_q};
									desc_s0.last = 1'b1;
								end
								CMD_END: begin
									phase_nxt = PH_DONE;
									emit_s0 = 1'b1;
									desc_s0.txv = 1'b1;
									desc_s0.data = {24'd0, ok_code_q};
									desc_s0.last = 1'b1;
									desc_s0.done = 1'b1;
								end
								default: begin
									emit_s0 = 1'b1;
									desc_s0.unk = 1'b1;
								end
							endcase
						end
						default: ;
					endcase
				end
				OP_TICK: begin
					if (phase_q == PH_STREAM) begin
						emit_s0 = 1'b1;
						desc_s0.txv = 1'b1;
						if (count_q < psize_q) begin
							rd_en = 1'b1;
							data_s0 = 1'b1;
							count_nxt = count_q + 12'd1;
						end else begin
							csum_s0 = 1'b1;
							desc_s0.last = 1'b1;
							pointer_nxt = pointer_q + {12'd0, psize_q};
							count_nxt = '0;
							phase_nxt = PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lane_q <= LANE_0;
			pointer_q <= '0;
			psize_q <= PACKET_SIZE_RST;
			count_q <= '0;
		end else begin
			phase_q <= phase_nxt;
			lane_q <= lane_nxt;
			pointer_q <= pointer_nxt;
			psize_q <= psize_nxt;
			count_q <= count_nxt;
		end
	end

	// A load and a stream read never share a cycle, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[STORE_AW'(load_addr)] <= load_byte;
		end
		if (rd_en) begin
			rd_data_s1 <= store_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			data_s1 <= 1'b0;
			csum_s1 <= 1'b0;
		end else begin
			v_s1 <= emit_s0;
			data_s1 <= data_s0;
			csum_s1 <= csum_s0;
		end
	end

	always_ff @(posedge clk) begin
		desc_s1 <= desc_s0;
		inr_s1 <= rd_inr;
	end

	assign data_byte = inr_s1 ? rd_data_s1 : 8'd0;

	always_comb begin
		push_desc = desc_s1;
		if (data_s1) begin
			push_desc.data = {24'd0, data_byte};
		end else if (csum_s1) begin
			push_desc.data = {24'd0, checksum_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checksum_q <= '0;
		end else if (data_s1) begin
			checksum_q <= checksum_q + data_byte;
		end else if (csum_s1) begin
			checksum_q <= '0;
		end
	end

	assign head = fq_q[rd_ptr_q];
	assign out_valid = (fq_cnt_q != '0);
	assign out_fire = out_valid && out_ready;
	assign last_beat = !head.multi || (beat_q == 2'd3);
	assign push = v_s1;
	assign pop = out_fire && last_beat;

	assign tx_valid = head.txv;
	assign tx_byte = head.data[{beat_q, 3'b000} +: 8];
	assign last_of_reply = head.multi ? (beat_q == 2'd3) : head.last;
	assign session_done = head.done;
	assign unknown_command = head.unk;

	always_ff @(posedge clk) begin
		if (push) begin
			fq_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fq_cnt_q <= '0;
			beat_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FQ_AW'(1);
			end
			fq_cnt_q <= fq_cnt_q + FQ_CW'(push) - FQ_CW'(pop);
			if (out_fire) begin
				beat_q <= last_beat ? 2'd0 : beat_q + 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fq_cnt_q <= FQ_CW'(FQ_DEPTH))
		else $error("reply queue overflow");

	a_beat_multi: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !head.multi) |-> (beat_q == 2'd0))
		else $error("beat count on a single-word reply");

	a_read_in_stream: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (phase_q == PH_STREAM))
		else $error("store read outside a stream");

	a_data_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (v_s1 && data_s1))
		else $error("store read without a data word");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the file packet server, with a predictor, random traffic and stalls.
`timescale 1ns / 100ps

module testbench;
	import fps_pkg::*;

	localparam int MODEL_DEPTH = DEF_STORE_DEPTH;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_QUOTA = 4;
	localparam int MAX_REPORTS = 10;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		phase_t ph;
		lane_t lane;
		logic [23:0] ptr;
		logic [11:0] psize;
		logic [11:0] cnt;
		logic [7:0] sum;
		logic [23:0] flen;
		logic [7:0] ok;
	} server_state_t;

	typedef struct packed {
		logic txv;
		logic [7:0] data;
		logic last;
		logic done;
		logic unk;
	} reply_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx;
		logic [15:0] addr;
		logic [7:0] data;
	} link_word_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_CHOPPY,
		RX_SLOW
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = OP_LINK;
	logic [7:0] rx_byte = 8'h00;
	logic [15:0] load_addr = 16'h0000;
	logic [7:0] load_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic tx_valid;
	logic [7:0] tx_byte;
	logic last_of_reply;
	logic session_done;
	logic unknown_command;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = REG_FILE_LENGTH;
	logic [23:0] cfg_data = 24'h000000;

	file_packet_server dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.rx_byte(rx_byte),
		.load_addr(load_addr),
		.load_byte(load_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.last_of_reply(last_of_reply),
		.session_done(session_done),
		.unknown_command(unknown_command),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	server_state_t model_st;
	server_state_t plan_st;
	logic [7:0] file_img [MODEL_DEPTH];
	bit loaded [MODEL_DEPTH];
	link_word_t pending_words[$];
	reply_t reply_q[$];

	int cycles = 0;
	int words_in = 0;
	int words_sent = 0;
	int replies_checked = 0;
	int streams_done = 0;
	int cfg_writes = 0;
	int mismatches = 0;
	int useful_words = 0;
	int burst_left = 1;
	int gap_left = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int window_left = 0;
	rx_mode_t stall_mode = RX_FREE;
	logic ready_next;
	logic was_stream;
	int step_n;
	reply_t [3:0] step_out;
	reply_t exp_reply;
	reply_t got_reply;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic server_state_t fresh_state();
		server_state_t s;
		s.ph = PH_IDLE;
		s.lane = LANE_0;
		s.ptr = 24'h000000;
		s.psize = PACKET_SIZE_RST;
		s.cnt = 12'h000;
		s.sum = 8'h00;
		s.flen = 24'h000000;
		s.ok = 8'h00;
		return s;
	endfunction

	function automatic reply_t reply_of(logic txv, logic [7:0] data, logic last, logic done,
		logic unk);
		reply_t r;
		r.txv = txv;
		r.data = data;
		r.last = last;
		r.done = done;
		r.unk = unk;
		return r;
	endfunction

	function automatic logic [23:0] stream_addr(server_state_t s);
		return s.ptr + 24'(s.cnt);
	endfunction

	function automatic bit store_hit(server_state_t s, logic [23:0] a);
		return (a < s.flen) && (a < MODEL_DEPTH);
	endfunction

	// Advances one server state by one word and returns the number of replies.
	// Loads are applied to the file image by the caller.
	function automatic int serve_step(inout server_state_t s, input logic [1:0] op,
		input logic [7:0] rx, output reply_t [3:0] r);
		logic [23:0] a;
		logic [7:0] v;
		int n;
		n = 0;
		r = '0;
		if (op == OP_LINK) begin
			case (s.ph)
				PH_LANE: begin
					case (s.lane)
						LANE_0: s.ptr[7:0] = rx;
						LANE_1: s.ptr[15:8] = rx;
						LANE_2: s.ptr[23:16] = rx;
						default: ;
					endcase
					s.ph = PH_IDLE;
					r[0] = reply_of(1'b1, s.ok, 1'b1, 1'b0, 1'b0);
					n = 1;
				end
				PH_SIZE: begin
					s.psize = {rx, 4'h0};
					s.ph = PH_IDLE;
					r[0] = reply_of(1'b1, s.ok, 1'b1, 1'b0, 1'b0);
					n = 1;
				end
				PH_IDLE: begin
					case (rx)
						CMD_SIZE: begin
							r[0] = reply_of(1'b1, s.ok, 1'b0, 1'b0, 1'b0);
							r[1] = reply_of(1'b1, s.flen[7:0], 1'b0, 1'b0, 1'b0);
							r[2] = reply_of(1'b1, s.flen[15:8], 1'b0, 1'b0, 1'b0);
							r[3] = reply_of(1'b1, s.flen[23:16], 1'b1, 1'b0, 1'b0);
							n = 4;
						end
						CMD_LANE0: begin
							s.lane = LANE_0;
							s.ph = PH_LANE;
						end
						CMD_LANE1: begin
							s.lane = LANE_1;
							s.ph = PH_LANE;
						end
						CMD_LANE2: begin
							s.lane = LANE_2;
							s.ph = PH_LANE;
						end
						CMD_PSIZE: s.ph = PH_SIZE;
						CMD_STREAM: begin
							s.cnt = 12'h000;
							s.sum = 8'h00;
							s.ph = PH_STREAM;
						end
						CMD_BACK: begin
							s.ptr = s.ptr - 24'(s.psize);
							r[0] = reply_of(1'b1, s.ok, 1'b1, 1'b0, 1'b0);
							n = 1;
						end
						CMD_END: begin
							s.ph = PH_DONE;
							r[0] = reply_of(1'b1, s.ok, 1'b1, 1'b1, 1'b0);
							n = 1;
						end
						default: begin
							r[0] = reply_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
							n = 1;
						end
					endcase
				end
				default: ;
			endcase
		end else if (op == OP_TICK && s.ph == PH_STREAM) begin
			if (s.cnt < s.psize) begin
				a = stream_addr(s);
				v = store_hit(s, a) ? file_img[a[15:0]] : 8'h00;
				s.sum = s.sum + v;
				s.cnt = s.cnt + 12'd1;
				r[0] = reply_of(1'b1, v, 1'b0, 1'b0, 1'b0);
			end else begin
				r[0] = reply_of(1'b1, s.sum, 1'b1, 1'b0, 1'b0);
				s.ptr = s.ptr + 24'(s.psize);
				s.cnt = 12'h000;
				s.sum = 8'h00;
				s.ph = PH_IDLE;
			end
			n = 1;
		end
		return n;
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CMD_END)
			b = 8'h00;
		return b;
	endfunction

	// Queues one word. The planning copy of the state tracks the full server state
	// so that a store entry is loaded before any tick reads it.
	task automatic offer(input logic [1:0] op, input logic [7:0] rx, input logic [15:0] addr,
		input logic [7:0] data);
		server_state_t was;
		reply_t [3:0] unused;
		logic [23:0] a;
		int n;
		if (op == OP_TICK && plan_st.ph == PH_STREAM && plan_st.cnt < plan_st.psize) begin
			a = stream_addr(plan_st);
			if (store_hit(plan_st, a) && !loaded[a[15:0]]) begin
				loaded[a[15:0]] = 1'b1;
				pending_words.push_back({OP_LOAD, 8'($urandom_range(0, 255)), a[15:0],
					8'($urandom_range(0, 255))});
				useful_words++;
			end
		end
		if (op == OP_LOAD)
			loaded[addr] = 1'b1;
		was = plan_st;
		n = serve_step(plan_st, op, rx, unused);
		if (op == OP_LOAD || n > 0 || plan_st !== was)
			useful_words++;
		pending_words.push_back({op, rx, addr, data});
	endtask

	task automatic offer_link(input logic [7:0] b);
		offer(OP_LINK, b, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
	endtask

	task automatic offer_tick();
		offer(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic run_stream(input int noise_pct);
		offer_link(CMD_STREAM);
		while (plan_st.ph == PH_STREAM) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				if ($urandom_range(0, 1) == 0)
					offer_link(noise_byte());
				else
					offer(OP_LOAD, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
						8'($urandom_range(0, 255)));
			end
			offer_tick();
		end
	endtask

	task automatic random_phase(input int quota);
		int start;
		int pick;
		start = useful_words;
		while (useful_words - start < quota) begin
			pick = $urandom_range(0, 99);
			if (plan_st.ph == PH_STREAM)
				run_stream(10);
			else if (pick < 12)
				offer_link(CMD_SIZE);
			else if (pick < 30) begin
				case ($urandom_range(0, 2))
					0: begin
						offer_link(CMD_LANE0);
						offer_link(8'($urandom_range(0, 255)));
					end
					1: begin
						offer_link(CMD_LANE1);
						offer_link($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
							: 8'($urandom_range(0, 1)));
					end
					default: begin
						offer_link(CMD_LANE2);
						offer_link($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h00);
					end
				endcase
			end else if (pick < 40) begin
				offer_link(CMD_PSIZE);
				offer_link($urandom_range(0, 3) == 0 ? 8'h01 : 8'h00);
			end else if (pick < 58)
				run_stream(15);
			else if (pick < 64)
				offer_link(CMD_BACK);
			else if (pick < 74)
				offer(OP_LOAD, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			else if (pick < 82)
				offer_tick();
			else if (pick < 88)
				offer(OP_SPARE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			else
				offer_link(noise_byte());
		end
		if (plan_st.ph == PH_LANE || plan_st.ph == PH_SIZE)
			offer_link(8'h01);
		if (plan_st.ph == PH_STREAM)
			run_stream(0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		if (idx == REG_FILE_LENGTH)
			plan_st.flen = val;
		else
			plan_st.ok = val[7:0];
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || in_valid || reply_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && !(in_valid && words_in != words_sent)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				opcode <= pending_words[0].op;
				rx_byte <= pending_words[0].rx;
				load_addr <= pending_words[0].addr;
				load_byte <= pending_words[0].data;
				in_valid <= 1'b1;
				words_sent++;
				if (burst_left > 1)
					burst_left--;
				else if ($urandom_range(0, 7) == 0) begin
					burst_left = 40;
					gap_left = 0;
				end else begin
					burst_left = $urandom_range(1, 10);
					gap_left = $urandom_range(0, 6);
				end
			end else
				in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
				ready_next = 1'b0;
			end else begin
				if (window_left == 0) begin
					window_left = $urandom_range(8, 60);
					stall_mode = rx_mode_t'($urandom_range(0, 2));
				end
				window_left--;
				case (stall_mode)
					RX_FREE: ready_next = 1'b1;
					RX_CHOPPY: ready_next = 1'($urandom_range(0, 1));
					default: ready_next = ($urandom_range(0, 4) == 0);
				endcase
			end
			out_ready <= ready_next;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: no progress after %0d cycles", cycles);
			$display("testbench: errors");
			$finish;
		end else if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FILE_LENGTH)
					model_st.flen = cfg_data;
				else
					model_st.ok = cfg_data[7:0];
			end
			if (out_valid && out_ready) begin
				got_reply = {tx_valid, tx_byte, last_of_reply, session_done, unknown_command};
				if (reply_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected word: txv=%0d byte=%02h last=%0d done=%0d unk=%0d",
							got_reply.txv, got_reply.data, got_reply.last, got_reply.done,
							got_reply.unk);
				end else begin
					exp_reply = reply_q.pop_front();
					replies_checked++;
					if (got_reply !== exp_reply) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch at word %0d: expected txv=%0d byte=%02h last=%0d done=%0d unk=%0d, got txv=%0d byte=%02h last=%0d done=%0d unk=%0d",
								replies_checked, exp_reply.txv, exp_reply.data, exp_reply.last,
								exp_reply.done, exp_reply.unk, got_reply.txv, got_reply.data,
								got_reply.last, got_reply.done, got_reply.unk);
					end
				end
			end
			if (in_valid && in_ready) begin
				words_in++;
				if (opcode == OP_LOAD)
					file_img[load_addr] = load_byte;
				else begin
					was_stream = (model_st.ph == PH_STREAM);
					step_n = serve_step(model_st, opcode, rx_byte, step_out);
					for (int k = 0; k < step_n; k++)
						reply_q.push_back(step_out[k]);
					if (was_stream && step_n > 0 && step_out[0].last)
						streams_done++;
				end
				void'(pending_words.pop_front());
			end
		end
	end

	initial begin
		logic [23:0] len;
		logic [7:0] okv;
		model_st = fresh_state();
		plan_st = fresh_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_FILE_LENGTH, 24'h000123);
		write_reg(REG_OK_CODE, 24'h00005A);
		@(posedge clk);
		offer(OP_LOAD, 8'h00, 16'hFFFF, 8'hFF);
		offer(OP_LOAD, 8'hFF, 16'h0000, 8'h00);
		offer_link(CMD_SIZE);
		offer_link(8'h00);
		offer_link(8'hFF);
		offer_tick();
		offer(OP_SPARE, 8'hFF, 16'hFFFF, 8'hFF);
		// Pointer 0x000118: the packet runs past the end of the file.
		offer_link(CMD_LANE0);
		offer_link(8'h18);
		offer_link(CMD_LANE1);
		offer_link(8'h01);
		offer_link(CMD_LANE2);
		offer_link(8'h00);
		offer_link(CMD_PSIZE);
		offer_link(8'h01);
		run_stream(0);
		offer_link(CMD_BACK);
		// Step back from address eight so that the next packet wraps past the top.
		offer_link(CMD_LANE0);
		offer_link(8'h08);
		offer_link(CMD_LANE1);
		offer_link(8'h00);
		offer_link(CMD_BACK);
		offer_link(CMD_STREAM);
		repeat (4) offer_tick();
		offer_link(CMD_SIZE);
		offer(OP_LOAD, 8'h00, 16'h0004, 8'hC3);
		run_stream(0);
		offer_link(CMD_PSIZE);
		offer_link(8'h00);
		run_stream(0);
		offer_link(CMD_BACK);
		offer_link(CMD_PSIZE);
		offer_link(8'hFF);
		offer_link(CMD_BACK);
		offer_link(CMD_PSIZE);
		offer_link(8'h00);
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					len = 24'h000000;
					okv = 8'h00;
				end
				1: begin
					len = 24'hFFFFFF;
					okv = 8'hFF;
				end
				2: begin
					len = 24'($urandom_range(1, 600));
					okv = 8'($urandom_range(0, 255));
				end
				default: begin
					len = 24'($urandom_range(0, 24'hFFFFFF));
					okv = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(REG_FILE_LENGTH, len);
			write_reg(REG_OK_CODE, {16'h0000, okv});
			@(posedge clk);
			if (p == 1) begin
				hold_requests++;
				repeat (6) offer_link(CMD_SIZE);
			end
			random_phase(PHASE_QUOTA);
			drain();
		end

		// After the end command everything but loads is ignored.
		offer_link(CMD_END);
		offer_link(CMD_SIZE);
		offer_tick();
		offer_link(CMD_LANE0);
		offer(OP_LOAD, 8'h5A, 16'($urandom_range(0, 65535)), 8'hA5);
		offer_link(8'h00);
		drain();

		$display("run covered %0d words in, %0d replies checked, %0d packets streamed",
			words_in, replies_checked, streams_done);
		$display("%0d register writes over five settings, %0d mismatches", cfg_writes,
			mismatches);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
